// ----- src/esb_pkg.sv -----
// Shared types, constants and saturating arithmetic for the exact sector bend map.
// Used by every module of the block; depends on nothing.
package esb_pkg;

  typedef logic signed [63:0] w64_t;

  localparam w64_t W_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam w64_t W_MIN = 64'sh8000_0000_0000_0000;

  // multiplier pipeline depth
  localparam int MUL_LAT = 4;

  typedef enum logic [2:0] {
    CFG_BEND_RADIUS = 3'd0,
    CFG_COS_ANGLE   = 3'd1,
    CFG_SIN_ANGLE   = 3'd2,
    CFG_MOM_SCALE   = 3'd3,
    CFG_SLICE_LEN   = 3'd4
  } cfg_idx_t;

  // every intermediate of one particle, carried down the pipeline
  typedef struct packed {
    logic signed [63:0] x, p, y, yp, e;
    logic signed [63:0] d, p2, ypl, yn, omd, tm, p2m2, cm1;
    logic signed [63:0] h, dr, dpp, rom, cs, ss, w, g, u;
    logic signed [63:0] rw, dps, cdr, drdr, drp, pp2, drp2, uu, gr, cg;
    logic signed [63:0] xrw, dpsm1, tt;
    logic signed [63:0] ma1, ma2, q0, csdd, csdp, drp2u, cdrp;
    logic signed [63:0] a, q, t1, dent, tcd2;
    logic signed [63:0] qq, b2, tcs, sst, den0, b1, tt2, bf;
    logic signed [63:0] sq, xn, ggx, sn, tc, num, den, xa;
  } ctx_t;

  function automatic w64_t sadd(w64_t a, w64_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return a[63] ? W_MIN : W_MAX;
    return s[63:0];
  endfunction

  function automatic w64_t ssub(w64_t a, w64_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return a[63] ? W_MIN : W_MAX;
    return s[63:0];
  endfunction

endpackage

// ----- src/exact_sector_bend_map.sv -----
// Exact sector bend map, one particle word per cycle, fully pipelined.
// Built from six 4-stage multiply levels, the bit-per-stage square root and divider.
// Throughput: one word per cycle; a stalled output holds the whole pipeline.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register defaults.
module exact_sector_bend_map #(
  parameter int FRAC_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_x_in,
  input  logic [63:0] in_xangle_in,
  input  logic [63:0] in_y_in,
  input  logic [63:0] in_yangle_in,
  input  logic [63:0] in_mom_dev,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_x_out,
  output logic [63:0] out_xangle_out,
  output logic [63:0] out_y_out,
  output logic        out_invalid,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import esb_pkg::*;

  localparam w64_t ONE = 64'sd1 <<< FRAC_BITS;
  localparam w64_t TWO = ONE <<< 1;

  // configuration
  logic [63:0] rad_r;
  logic [33:0] cos_r, sin_r;
  logic [62:0] mom_r, len_r;
  w64_t        r, c, s, ps, len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r <= 64'(ONE);
      cos_r <= 34'(ONE);
      sin_r <= '0;
      mom_r <= 63'(ONE);
      len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BEND_RADIUS: rad_r <= cfg_wdata;
        CFG_COS_ANGLE:   cos_r <= cfg_wdata[33:0];
        CFG_SIN_ANGLE:   sin_r <= cfg_wdata[33:0];
        CFG_MOM_SCALE:   mom_r <= cfg_wdata[62:0];
        CFG_SLICE_LEN:   len_r <= cfg_wdata[62:0];
        default: ;
      endcase
    end
  end

  assign r   = rad_r;
  assign c   = 64'($signed(cos_r));
  assign s   = 64'($signed(sin_r));
  assign ps  = {1'b0, mom_r};
  assign len = {1'b0, len_r};

  // global advance: the output register is free or being taken
  logic en;
  logic out_v_r;
  assign en       = !out_v_r || !out_stall;
  assign in_stall = !en;

  // entry stage
  ctx_t ctx0_r, ctx0_nxt;
  logic v0_r;
  always_comb begin
    ctx0_nxt   = '0;
    ctx0_nxt.x  = in_x_in;
    ctx0_nxt.p  = in_xangle_in;
    ctx0_nxt.y  = in_y_in;
    ctx0_nxt.yp = in_yangle_in;
    ctx0_nxt.e  = sadd(ONE, in_mom_dev);
  end

  // level 1
  w64_t [2:0] l1_a, l1_b, l1_p;
  ctx_t       l1_ctx, ctx1_r, ctx1_nxt;
  logic       l1_v, v1_r;
  assign l1_a = {ctx0_r.yp, ps, ctx0_r.p};
  assign l1_b = {len, ctx0_r.e, ctx0_r.p};
  esb_level #(.FRAC_BITS(FRAC_BITS), .NLANE(3)) u_l1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v0_r), .in_ctx(ctx0_r),
    .op_a(l1_a), .op_b(l1_b), .out_v(l1_v), .out_ctx(l1_ctx), .prod(l1_p)
  );
  always_comb begin
    ctx1_nxt      = l1_ctx;
    ctx1_nxt.p2   = l1_p[0];
    ctx1_nxt.d    = l1_p[1];
    ctx1_nxt.ypl  = l1_p[2];
    ctx1_nxt.yn   = sadd(ctx1_nxt.y, ctx1_nxt.ypl);
    ctx1_nxt.omd  = ssub(ONE, ctx1_nxt.d);
    ctx1_nxt.tm   = ssub(TWO, sadd(ctx1_nxt.d, ctx1_nxt.d));
    ctx1_nxt.p2m2 = ssub(ctx1_nxt.p2, TWO);
    ctx1_nxt.cm1  = ssub(c, ONE);
  end

  // level 2
  w64_t [5:0] l2_a, l2_b, l2_p;
  ctx_t       l2_ctx, ctx2_r, ctx2_nxt;
  logic       l2_v, v2_r;
  assign l2_a = {s, c, r, ctx1_r.d, ctx1_r.d, ctx1_r.d};
  assign l2_b = {s, s, ctx1_r.omd, ctx1_r.p, r, ctx1_r.p2};
  esb_level #(.FRAC_BITS(FRAC_BITS), .NLANE(6)) u_l2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v1_r), .in_ctx(ctx1_r),
    .op_a(l2_a), .op_b(l2_b), .out_v(l2_v), .out_ctx(l2_ctx), .prod(l2_p)
  );
  always_comb begin
    ctx2_nxt     = l2_ctx;
    ctx2_nxt.h   = l2_p[0];
    ctx2_nxt.dr  = l2_p[1];
    ctx2_nxt.dpp = l2_p[2];
    ctx2_nxt.rom = l2_p[3];
    ctx2_nxt.cs  = l2_p[4];
    ctx2_nxt.ss  = l2_p[5];
    ctx2_nxt.w   = sadd(ctx2_nxt.omd, ctx2_nxt.h >>> 1);
    ctx2_nxt.g   = sadd(ctx2_nxt.tm, ctx2_nxt.h);
    ctx2_nxt.u   = sadd(ctx2_nxt.rom, ctx2_nxt.x);
  end

  // level 3
  w64_t [9:0] l3_a, l3_b, l3_p;
  ctx_t       l3_ctx, ctx3_r, ctx3_nxt;
  logic       l3_v, v3_r;
  assign l3_a = {c, ctx2_r.g, ctx2_r.u, ctx2_r.dr, ctx2_r.p, ctx2_r.dr, ctx2_r.dr,
                 c, ctx2_r.dpp, r};
  assign l3_b = {ctx2_r.g, r, ctx2_r.u, ctx2_r.p2, ctx2_r.p2, ctx2_r.p, ctx2_r.dr,
                 ctx2_r.dr, s, ctx2_r.w};
  esb_level #(.FRAC_BITS(FRAC_BITS), .NLANE(10)) u_l3 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v2_r), .in_ctx(ctx2_r),
    .op_a(l3_a), .op_b(l3_b), .out_v(l3_v), .out_ctx(l3_ctx), .prod(l3_p)
  );
  always_comb begin
    ctx3_nxt       = l3_ctx;
    ctx3_nxt.rw    = l3_p[0];
    ctx3_nxt.dps   = l3_p[1];
    ctx3_nxt.cdr   = l3_p[2];
    ctx3_nxt.drdr  = l3_p[3];
    ctx3_nxt.drp   = l3_p[4];
    ctx3_nxt.pp2   = l3_p[5];
    ctx3_nxt.drp2  = l3_p[6];
    ctx3_nxt.uu    = l3_p[7];
    ctx3_nxt.gr    = l3_p[8];
    ctx3_nxt.cg    = l3_p[9];
    ctx3_nxt.xrw   = sadd(ctx3_nxt.x, ctx3_nxt.rw);
    ctx3_nxt.dpsm1 = ssub(ctx3_nxt.dps, ONE);
    ctx3_nxt.tt    = sadd(ctx3_nxt.dps, ctx3_nxt.dps);
  end

  // level 4
  w64_t [6:0] l4_a, l4_b, l4_p;
  ctx_t       l4_ctx, ctx4_r, ctx4_nxt;
  logic       l4_v, v4_r;
  assign l4_a = {ctx3_r.cdr, ctx3_r.drp2, ctx3_r.cs, ctx3_r.cs, ctx3_r.cdr, r, ctx3_r.xrw};
  assign l4_b = {ctx3_r.p, ctx3_r.u, ctx3_r.drp, ctx3_r.drdr, ctx3_r.p2m2, ctx3_r.dpsm1, c};
  esb_level #(.FRAC_BITS(FRAC_BITS), .NLANE(7)) u_l4 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v3_r), .in_ctx(ctx3_r),
    .op_a(l4_a), .op_b(l4_b), .out_v(l4_v), .out_ctx(l4_ctx), .prod(l4_p)
  );
  always_comb begin
    ctx4_nxt       = l4_ctx;
    ctx4_nxt.ma1   = l4_p[0];
    ctx4_nxt.ma2   = l4_p[1];
    ctx4_nxt.q0    = l4_p[2];
    ctx4_nxt.csdd  = l4_p[3];
    ctx4_nxt.csdp  = l4_p[4];
    ctx4_nxt.drp2u = l4_p[5];
    ctx4_nxt.cdrp  = l4_p[6];
    ctx4_nxt.a     = sadd(ctx4_nxt.ma1, ctx4_nxt.ma2);
    ctx4_nxt.q     = ctx4_nxt.q0 >>> 1;
    ctx4_nxt.t1    = sadd(ssub(ctx4_nxt.uu, ctx4_nxt.drdr), ctx4_nxt.drp2u);
    ctx4_nxt.dent  = ssub(sadd(ctx4_nxt.cg, ctx4_nxt.tt), TWO);
    ctx4_nxt.tcd2  = sadd(ctx4_nxt.cdrp, ctx4_nxt.cdrp);
  end

  // level 5
  w64_t [4:0] l5_a, l5_b, l5_p;
  ctx_t       l5_ctx, ctx5_r, ctx5_nxt, ctx6_r, ctx6_nxt;
  logic       l5_v, v5_r, v6_r;
  assign l5_a = {r, ctx4_r.ss, ctx4_r.csdp, ctx4_r.csdd, ctx4_r.q};
  assign l5_b = {ctx4_r.dent, ctx4_r.t1, ctx4_r.u, ctx4_r.pp2, ctx4_r.q};
  esb_level #(.FRAC_BITS(FRAC_BITS), .NLANE(5)) u_l5 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v4_r), .in_ctx(ctx4_r),
    .op_a(l5_a), .op_b(l5_b), .out_v(l5_v), .out_ctx(l5_ctx), .prod(l5_p)
  );
  always_comb begin
    ctx5_nxt      = l5_ctx;
    ctx5_nxt.qq   = l5_p[0];
    ctx5_nxt.b2   = l5_p[1];
    ctx5_nxt.tcs  = l5_p[2];
    ctx5_nxt.sst  = l5_p[3];
    ctx5_nxt.den0 = l5_p[4];
    ctx5_nxt.b1   = sadd(ctx5_nxt.qq, ctx5_nxt.b2);
    ctx5_nxt.tt2  = sadd(ctx5_nxt.tcs, ctx5_nxt.tcs);
    ctx6_nxt      = ctx5_r;
    ctx6_nxt.bf   = ssub(sadd(ctx5_r.b1, ctx5_r.tt2), ctx5_r.sst);
  end

  // square root of the discriminant
  ctx_t sq_ctx, ctx7_r, ctx7_nxt, ctx8_r, ctx8_nxt;
  logic sq_v, v7_r, v8_r;
  esb_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v6_r), .in_ctx(ctx6_r),
    .out_v(sq_v), .out_ctx(sq_ctx)
  );
  always_comb begin
    ctx7_nxt     = sq_ctx;
    ctx7_nxt.xn  = sq_ctx.a[63] ? sadd(sq_ctx.a, sq_ctx.sq) : ssub(sq_ctx.a, sq_ctx.sq);
    ctx8_nxt     = ctx7_r;
    ctx8_nxt.ggx = sadd(ctx7_r.gr, sadd(ctx7_r.xn, ctx7_r.xn));
  end

  // level 6: numerator and denominator
  w64_t [1:0] l6_a, l6_b, l6_p;
  ctx_t       l6_ctx, ctx9_r, ctx9_nxt;
  logic       l6_v, v9_r;
  assign l6_a = {ctx8_r.cm1, s};
  assign l6_b = {ctx8_r.xn, ctx8_r.ggx};
  esb_level #(.FRAC_BITS(FRAC_BITS), .NLANE(2)) u_l6 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v8_r), .in_ctx(ctx8_r),
    .op_a(l6_a), .op_b(l6_b), .out_v(l6_v), .out_ctx(l6_ctx), .prod(l6_p)
  );
  always_comb begin
    ctx9_nxt     = l6_ctx;
    ctx9_nxt.sn  = l6_p[0];
    ctx9_nxt.tc  = l6_p[1];
    ctx9_nxt.num = ssub(ctx9_nxt.sn, ctx9_nxt.tcd2);
    ctx9_nxt.den = sadd(ctx9_nxt.den0, sadd(ctx9_nxt.tc, ctx9_nxt.tc));
  end

  // divider
  ctx_t dv_ctx;
  logic dv_v, bad;
  esb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v9_r), .in_ctx(ctx9_r),
    .out_v(dv_v), .out_ctx(dv_ctx)
  );
  assign bad = dv_ctx.bf[63] || (dv_ctx.den == '0);

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid; v1_r <= l1_v; v2_r <= l2_v; v3_r <= l3_v; v4_r <= l4_v;
      v5_r <= l5_v; v6_r <= v5_r; v7_r <= sq_v; v8_r <= v7_r; v9_r <= l6_v;
      out_v_r <= dv_v;
    end
  end

  logic [63:0] x_r, xa_r, y_r;
  logic        inv_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ctx0_r <= ctx0_nxt; ctx1_r <= ctx1_nxt; ctx2_r <= ctx2_nxt; ctx3_r <= ctx3_nxt;
      ctx4_r <= ctx4_nxt; ctx5_r <= ctx5_nxt; ctx6_r <= ctx6_nxt; ctx7_r <= ctx7_nxt;
      ctx8_r <= ctx8_nxt; ctx9_r <= ctx9_nxt;
      x_r    <= bad ? '0 : dv_ctx.xn;
      xa_r   <= bad ? '0 : dv_ctx.xa;
      y_r    <= bad ? '0 : dv_ctx.yn;
      inv_r  <= bad;
    end
  end

  assign out_valid      = out_v_r;
  assign out_x_out      = x_r;
  assign out_xangle_out = xa_r;
  assign out_y_out      = y_r;
  assign out_invalid    = inv_r;

  // an invalid word carries zero results
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_x_out == '0 && out_xangle_out == '0 && out_y_out == '0)
    else $error("invalid word with non-zero results");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // writes beyond the register list change nothing
  a_cfg_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index > CFG_SLICE_LEN |=> $stable(rad_r) && $stable(cos_r)
      && $stable(sin_r) && $stable(mom_r) && $stable(len_r))
    else $error("out of range register write took effect");

endmodule

// ----- src/esb_fmul.sv -----
// Pipelined fixed point multiplier: 32x32 partial products, sum, sign, shift and saturate.
// Depends on esb_pkg.
module esb_fmul #(
  parameter int FRAC_BITS = 32
) (
  input  logic          clk,
  input  logic          en,
  input  esb_pkg::w64_t a,
  input  esb_pkg::w64_t b,
  output esb_pkg::w64_t p
);
  import esb_pkg::*;

  logic [63:0]         ma, mb;
  logic [63:0]         pp00_r, pp01_r, pp10_r, pp11_r;
  logic                neg1_r, neg2_r;
  logic [127:0]        sum_r;
  logic signed [127:0] prod_r;
  logic signed [127:0] sh;
  logic                fits;
  w64_t                p_r;

  assign ma = a[63] ? (~a + 64'd1) : a;
  assign mb = b[63] ? (~b + 64'd1) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= ma[31:0]  * mb[31:0];
      pp01_r <= ma[31:0]  * mb[63:32];
      pp10_r <= ma[63:32] * mb[31:0];
      pp11_r <= ma[63:32] * mb[63:32];
      neg1_r <= a[63] ^ b[63];
      sum_r  <= {64'd0, pp00_r} + {32'd0, pp01_r, 32'd0} + {32'd0, pp10_r, 32'd0}
                + {pp11_r, 64'd0};
      neg2_r <= neg1_r;
      prod_r <= neg2_r ? -$signed(sum_r) : $signed(sum_r);
      p_r    <= fits ? sh[63:0] : (sh[127] ? W_MIN : W_MAX);
    end
  end

  // floor shift, then range check on the upper bits
  assign sh   = prod_r >>> FRAC_BITS;
  assign fits = (&sh[127:63]) | ~(|sh[127:63]);
  assign p    = p_r;

endmodule

// ----- src/esb_level.sv -----
// One multiply level: a bank of pipelined multipliers with the particle word delayed alongside.
// Depends on esb_pkg and esb_fmul.
module esb_level #(
  parameter int FRAC_BITS = 32,
  parameter int NLANE     = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_v,
  input  esb_pkg::ctx_t                   in_ctx,
  input  esb_pkg::w64_t [NLANE-1:0]       op_a,
  input  esb_pkg::w64_t [NLANE-1:0]       op_b,
  output logic                            out_v,
  output esb_pkg::ctx_t                   out_ctx,
  output esb_pkg::w64_t [NLANE-1:0]       prod
);
  import esb_pkg::*;

  logic [MUL_LAT-1:0] v_r;
  ctx_t               ctx_r [MUL_LAT];

  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    esb_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (op_a[i]),
      .b   (op_b[i]),
      .p   (prod[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[MUL_LAT-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= in_ctx;
      for (int i = 1; i < MUL_LAT; i++) ctx_r[i] <= ctx_r[i-1];
    end
  end

  assign out_v   = v_r[MUL_LAT-1];
  assign out_ctx = ctx_r[MUL_LAT-1];

endmodule

// ----- src/esb_sqrt.sv -----
// Pipelined digit-by-digit square root of (bf << FRAC_BITS), one root bit per stage.
// Depends on esb_pkg.
module esb_sqrt #(
  parameter int FRAC_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  esb_pkg::ctx_t in_ctx,
  output logic          out_v,
  output esb_pkg::ctx_t out_ctx
);
  import esb_pkg::*;

  localparam int RB = ((64 + FRAC_BITS + 1) / 2) * 2;
  localparam int NS = RB / 2;
  localparam int RW = NS + 3;

  logic [RB-1:0] rad_r  [NS];
  logic [NS-1:0] root_r [NS];
  logic [RW-1:0] rem_r  [NS];
  ctx_t          ctx_r  [NS];
  logic [NS-1:0] v_r;

  logic [RB-1:0] rad_nxt  [NS];
  logic [NS-1:0] root_nxt [NS];
  logic [RW-1:0] rem_nxt  [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [RB-1:0] rad_in;
    logic [NS-1:0] root_in;
    logic [RW-1:0] rem_in, rem2, trial;
    if (i == 0) begin : g_first
      assign rad_in  = RB'({in_ctx.bf, {FRAC_BITS{1'b0}}});
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign root_in = root_r[i-1];
      assign rem_in  = rem_r[i-1];
    end
    assign rem2  = {rem_in[RW-3:0], rad_in[RB-1 -: 2]};
    assign trial = RW'({root_in, 2'b01});
    always_comb begin
      rad_nxt[i] = {rad_in[RB-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem_nxt[i]  = rem2 - trial;
        root_nxt[i] = {root_in[NS-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = rem2;
        root_nxt[i] = {root_in[NS-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i]  <= rad_nxt[i];
        root_r[i] <= root_nxt[i];
        rem_r[i]  <= rem_nxt[i];
        ctx_r[i]  <= (i == 0) ? in_ctx : ctx_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_v};
    end
  end

  always_comb begin
    out_ctx    = ctx_r[NS-1];
    out_ctx.sq = 64'(root_r[NS-1]);
  end
  assign out_v = v_r[NS-1];

endmodule

// ----- src/esb_div.sv -----
// Pipelined restoring divider for (num << FRAC_BITS) / den, one quotient bit per stage,
// with truncation toward zero and saturation. Depends on esb_pkg.
module esb_div #(
  parameter int FRAC_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  esb_pkg::ctx_t in_ctx,
  output logic          out_v,
  output esb_pkg::ctx_t out_ctx
);
  import esb_pkg::*;

  localparam int DW = 64 + FRAC_BITS;
  localparam int ND = DW;

  // pre stage: magnitudes
  logic [DW-1:0] dv0_r;
  logic [63:0]   ud0_r;
  logic          neg0_r, v0_r;
  ctx_t          ctx0_r;

  logic [DW-1:0] dv_r  [ND];
  logic [DW-1:0] quo_r [ND];
  logic [64:0]   rem_r [ND];
  logic [63:0]   ud_r  [ND];
  logic          neg_r [ND];
  ctx_t          ctx_r [ND];
  logic [ND-1:0] v_r;

  ctx_t          fin_r;
  logic          finv_r;
  logic [63:0]   un, ud;
  w64_t          xa_nxt;
  logic [DW-1:0] qf;

  assign un = in_ctx.num[63] ? (~in_ctx.num + 64'd1) : in_ctx.num;
  assign ud = in_ctx.den[63] ? (~in_ctx.den + 64'd1) : in_ctx.den;

  always_ff @(posedge clk) begin
    if (en) begin
      dv0_r  <= {un, {FRAC_BITS{1'b0}}};
      ud0_r  <= ud;
      neg0_r <= in_ctx.num[63] ^ in_ctx.den[63];
      ctx0_r <= in_ctx;
    end
  end

  for (genvar i = 0; i < ND; i++) begin : g_stage
    logic [DW-1:0] dv_in, quo_in;
    logic [64:0]   rem_in, rem2;
    logic [63:0]   ud_in;
    logic          neg_in, ge;
    ctx_t          ctx_in;
    if (i == 0) begin : g_first
      assign dv_in  = dv0_r;
      assign quo_in = '0;
      assign rem_in = '0;
      assign ud_in  = ud0_r;
      assign neg_in = neg0_r;
      assign ctx_in = ctx0_r;
    end else begin : g_next
      assign dv_in  = dv_r[i-1];
      assign quo_in = quo_r[i-1];
      assign rem_in = rem_r[i-1];
      assign ud_in  = ud_r[i-1];
      assign neg_in = neg_r[i-1];
      assign ctx_in = ctx_r[i-1];
    end
    assign rem2 = {rem_in[63:0], dv_in[DW-1]};
    assign ge   = rem2 >= {1'b0, ud_in};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[i]  <= {dv_in[DW-2:0], 1'b0};
        rem_r[i] <= ge ? (rem2 - {1'b0, ud_in}) : rem2;
        quo_r[i] <= {quo_in[DW-2:0], ge};
        ud_r[i]  <= ud_in;
        neg_r[i] <= neg_in;
        ctx_r[i] <= ctx_in;
      end
    end
  end

  assign qf = quo_r[ND-1];
  always_comb begin
    if (neg_r[ND-1]) begin
      if ((|qf[DW-1:64]) || (qf[63:0] > 64'h8000_0000_0000_0000)) xa_nxt = W_MIN;
      else xa_nxt = -$signed(qf[63:0]);
    end else begin
      if (|qf[DW-1:63]) xa_nxt = W_MAX;
      else xa_nxt = $signed(qf[63:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r    <= ctx_r[ND-1];
      fin_r.xa <= xa_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v_r    <= '0;
      finv_r <= 1'b0;
    end else if (en) begin
      v0_r   <= in_v;
      v_r    <= {v_r[ND-2:0], v0_r};
      finv_r <= v_r[ND-1];
    end
  end

  assign out_v   = finv_r;
  assign out_ctx = fin_r;

endmodule

// ----- dv/esb_checker.sv -----
// Checker for exact_sector_bend_map: tracks config writes, predicts each result
// word from accepted input words and compares the output channel. Needs esb_pkg.
`timescale 1ns / 1ps
module esb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] in_x_in,
  input  logic [63:0] in_xangle_in,
  input  logic [63:0] in_y_in,
  input  logic [63:0] in_yangle_in,
  input  logic [63:0] in_mom_dev,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_x_out,
  input  logic [63:0] out_xangle_out,
  input  logic [63:0] out_y_out,
  input  logic        out_invalid,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          n_fail,
  output int          n_pending,
  output int          n_results,
  output int          n_invalid
);
  import esb_pkg::*;

  localparam int FB = 32;

  typedef struct packed {
    logic [63:0] xn, xa, yn;
    logic        inv;
  } track_t;

  track_t      track_q[$];
  logic [63:0] rho, cang, sang, mscale, slen;

  // product shifted right by FB, floor, then saturated
  function automatic w64_t fx_mul(w64_t a, w64_t b);
    logic signed [127:0] p, s;
    p = 128'(a) * 128'(b);
    s = p >>> FB;
    if (s > 128'(W_MAX)) return W_MAX;
    if (s < 128'(W_MIN)) return W_MIN;
    return s[63:0];
  endfunction

  function automatic w64_t fx_sqrt(w64_t b);
    logic [127:0] n, t;
    logic [63:0]  r;
    n = 128'($unsigned(b)) << FB;
    r = 0;
    for (int k = 63; k >= 0; k--) begin
      t = 128'(r | (64'd1 << k));
      if (t * t <= n) r = r | (64'd1 << k);
    end
    return r;
  endfunction

  function automatic w64_t fx_div(w64_t num, w64_t den);
    logic signed [127:0] n, q;
    n = 128'(num) <<< FB;
    q = n / 128'(den);
    if (q > 128'(W_MAX)) return W_MAX;
    if (q < 128'(W_MIN)) return W_MIN;
    return q[63:0];
  endfunction

  function automatic track_t bend_particle(w64_t x, w64_t p, w64_t y, w64_t yp, w64_t dp);
    w64_t one, two, r, c, s, p2, d, h, w, g, dr, u, a, q, cs, b, t, xn, num, den, yn;
    track_t res;
    one = 64'sd1 <<< FB;
    two = sadd(one, one);
    r = rho; c = cang; s = sang;
    p2 = fx_mul(p, p);
    d = fx_mul(mscale, sadd(one, dp));
    h = fx_mul(d, p2);
    w = sadd(ssub(one, d), h >>> 1);
    g = sadd(ssub(two, sadd(d, d)), h);
    dr = fx_mul(d, r);
    u = sadd(fx_mul(r, ssub(one, d)), x);
    a = sadd(fx_mul(sadd(x, fx_mul(r, w)), c),
             fx_mul(r, ssub(fx_mul(fx_mul(d, p), s), one)));
    q = fx_mul(fx_mul(c, dr), ssub(p2, two)) >>> 1;
    cs = fx_mul(c, s);
    b = fx_mul(q, q);
    b = sadd(b, fx_mul(fx_mul(cs, fx_mul(dr, dr)), fx_mul(p, p2)));
    t = fx_mul(fx_mul(cs, fx_mul(dr, p)), u);
    b = sadd(b, sadd(t, t));
    t = sadd(ssub(fx_mul(u, u), fx_mul(dr, dr)), fx_mul(fx_mul(dr, p2), u));
    b = ssub(b, fx_mul(fx_mul(s, s), t));
    yn = sadd(y, fx_mul(yp, slen));
    res = '{xn: 0, xa: 0, yn: 0, inv: 1'b1};
    if (b < 0) return res;
    xn = (a < 0) ? sadd(a, fx_sqrt(b)) : ssub(a, fx_sqrt(b));
    t = fx_mul(fx_mul(c, dr), p);
    num = ssub(fx_mul(s, sadd(fx_mul(g, r), sadd(xn, xn))), sadd(t, t));
    t = fx_mul(fx_mul(d, p), s);
    den = fx_mul(r, ssub(sadd(fx_mul(c, g), sadd(t, t)), two));
    t = fx_mul(ssub(c, one), xn);
    den = sadd(den, sadd(t, t));
    if (den == 0) return res;
    res = '{xn: xn, xa: fx_div(num, den), yn: yn, inv: 1'b0};
    return res;
  endfunction

  assign n_pending = track_q.size();

  always @(posedge clk) begin
    track_t e;
    if (!rst_n) begin
      rho <= 64'sd1 <<< FB; cang <= 64'sd1 <<< FB; sang <= 0;
      mscale <= 64'sd1 <<< FB; slen <= 0;
      track_q.delete();
      n_fail <= 0; n_results <= 0; n_invalid <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BEND_RADIUS: rho <= cfg_wdata;
          CFG_COS_ANGLE:   cang <= {{30{cfg_wdata[33]}}, cfg_wdata[33:0]};
          CFG_SIN_ANGLE:   sang <= {{30{cfg_wdata[33]}}, cfg_wdata[33:0]};
          CFG_MOM_SCALE:   mscale <= {1'b0, cfg_wdata[62:0]};
          CFG_SLICE_LEN:   slen <= {1'b0, cfg_wdata[62:0]};
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        track_q.push_back(bend_particle(in_x_in, in_xangle_in, in_y_in, in_yangle_in,
                                        in_mom_dev));
      if (out_valid && !out_stall) begin
        n_results <= n_results + 1;
        if (track_q.size() == 0) begin
          $error("result word with nothing expected");
          n_fail <= n_fail + 1;
        end else begin
          e = track_q.pop_front();
          if (e.inv) n_invalid <= n_invalid + 1;
          if (out_x_out !== e.xn || out_xangle_out !== e.xa || out_y_out !== e.yn ||
              out_invalid !== e.inv) n_fail <= n_fail + 1;
          if (out_x_out !== e.xn)
            $error("x_out: expected %h, got %h", e.xn, out_x_out);
          if (out_xangle_out !== e.xa)
            $error("xangle_out: expected %h, got %h", e.xa, out_xangle_out);
          if (out_y_out !== e.yn)
            $error("y_out: expected %h, got %h", e.yn, out_y_out);
          if (out_invalid !== e.inv)
            $error("invalid: expected %b, got %b", e.inv, out_invalid);
        end
      end
    end
  end
endmodule

// ----- dv/testbench.sv -----
// Top of the exact_sector_bend_map testbench: clock, reset, config phases,
// directed and random particle words. Needs esb_pkg, esb_checker and the block.
`timescale 1ns / 1ps
module testbench;
  import esb_pkg::*;

  localparam int LATENCY = 181;
  localparam logic [63:0] ONE = 64'h1_0000_0000;

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall, out_invalid, cfg_we;
  logic [63:0] in_x_in, in_xangle_in, in_y_in, in_yangle_in, in_mom_dev;
  logic [63:0] out_x_out, out_xangle_out, out_y_out, cfg_wdata;
  logic [2:0]  cfg_index;
  int          n_fail, n_pending, n_results, n_invalid;
  bit          calm;

  exact_sector_bend_map i_dut (.*);
  esb_checker i_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("** exact_sector_bend_map: FAILED **");
    $finish;
  end

  // receiver stalls about 23 in 100, none while calm
  always @(negedge clk)
    if (!rst_n) out_stall <= 0;
    else out_stall <= !calm && ($urandom_range(99) < 23);

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // mostly small, physical values; sometimes any pattern
  function automatic logic [63:0] pick(int span);
    case ($urandom_range(9))
      0: return rnd64();
      1: return $urandom_range(1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
      default: return 64'($signed(rnd64()) >>> (64 - span));
    endcase
  endfunction

  // valid stays high from one word to the next unless an idle cycle is drawn
  task automatic send(logic [63:0] x, xa, y, ya, dp);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_x_in <= x; in_xangle_in <= xa;
    in_y_in <= y; in_yangle_in <= ya; in_mom_dev <= dp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (n_pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic set_bend(logic [63:0] r, c, s, m, l);
    drain();
    write_reg(CFG_BEND_RADIUS, r);
    write_reg(CFG_COS_ANGLE, c);
    write_reg(CFG_SIN_ANGLE, s);
    write_reg(CFG_MOM_SCALE, m);
    write_reg(CFG_SLICE_LEN, l);
    cfg_we <= 0;
  endtask

  initial begin
    logic [63:0] ext[5];
    rst_n = 0; in_valid = 0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0; calm = 0;
    {in_x_in, in_xangle_in, in_y_in, in_yangle_in, in_mom_dev} = '0;
    repeat (12) @(negedge clk);
    rst_n = 1;

    // directed, reset settings: field extremes and zeros
    ext = '{64'h0, ONE, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'hFFFF_FFFF_FFFF_FFFF};
    foreach (ext[i]) send(ext[i], ext[(i+1)%5], ext[(i+2)%5], ext[(i+3)%5], ext[(i+4)%5]);
    send(0, 0, 0, 0, 0);
    // gentle bend of about 0.1 rad, typical particles
    set_bend(64'd10 << 32, 64'h0_FE71_4D80, 64'h0_198F_2750, ONE, ONE);
    send(64'h100_0000, 64'h10_0000, ONE, 64'h10_0000, 64'h100_0000);
    send(64'hFFFF_FFFF_FF00_0000, 64'hFFFF_FFFF_FFF0_0000, 0, 0, 64'hFFFF_FFFF_FF00_0000);
    send(64'd50 << 32, 64'd3 << 32, 0, 0, 0);           // large x: negative discriminant
    send(0, 0, 0, 0, 64'hFFFF_FFFF_0000_0000);          // d of zero
    // extremes of the radius, momentum scale and slice length registers
    set_bend(64'h8000_0000_0000_0000, 64'h3_0000_0000, 64'h1_0000_0000,
             64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 6; i++) send(pick(36), pick(32), rnd64(), pick(33), pick(33));
    set_bend(64'h7FFF_FFFF_FFFF_FFFF, 64'h2_0000_0000, 64'h3_0000_0000, 0, 0);
    for (int i = 0; i < 6; i++) send(pick(36), pick(32), rnd64(), pick(33), pick(33));

    // random phases, several geometries
    for (int ph = 0; ph < 8; ph++) begin
      set_bend(ph == 7 ? rnd64() : pick(40),
               {30'b0, $urandom_range(1) ? 34'(ONE) : 34'(rnd64())},
               pick(33), ph == 6 ? rnd64() : ONE + pick(28), pick(36));
      calm = (ph == 3);
      for (int i = 0; i < 160; i++)
        send(pick(34), pick(31), pick(40), pick(32), pick(29));
      calm = 0;
    end

    drain();
    if (n_pending != 0) begin
      $display("** exact_sector_bend_map: FAILED **");
    end else begin
      $display("covered %0d result words (%0d flagged invalid) over 12 register settings",
               n_results, n_invalid);
      if (n_fail == 0) begin
        $display("** exact_sector_bend_map: PASSED **");
      end else begin
        $display("** exact_sector_bend_map: FAILED **");
      end
    end
    $finish;
  end
endmodule
